### hw/rtl/wts_pkg.sv
// Package for the waypoint time scheduler.
// Widths, codes and handshake types shared by all modules; no dependencies.
`timescale 1ns / 1ps
package wts_pkg;
  localparam int MaxWp  = 64;
  localparam int IdxW   = $clog2(MaxWp);
  localparam int CntW   = $clog2(MaxWp + 1);
  localparam int OutIdxW = 6;
  localparam int TimeW  = 40;
  localparam int CoordW = 32;
  localparam int MagW   = 33;
  localparam int ProdW  = 2 * MagW;
  localparam int RootW  = 33;
  localparam int NumW   = RootW + 16;
  localparam int DenW   = 32;
  localparam int SfW    = 17;
  localparam int StepW  = 6;
  localparam int InDataW  = 136;
  localparam int OutDataW = 56;

  localparam logic [2:0] RegStartX = 3'd0;
  localparam logic [2:0] RegStartY = 3'd1;
  localparam logic [2:0] RegStartZ = 3'd2;
  localparam logic [2:0] RegMaxSpd = 3'd3;
  localparam logic [2:0] RegSpdFac = 3'd4;
  localparam logic [2:0] RegSettle = 3'd5;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [SfW-1:0] SfOne = 17'h10000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;
endpackage

### hw/rtl/wts_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wts_pkg.
`timescale 1ns / 1ps
module wts_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [wts_pkg::MagW-1:0] a_i,
  input  logic [wts_pkg::MagW-1:0] b_i,
  output wts_pkg::unit_sts_t       sts_o,
  output logic [wts_pkg::ProdW-1:0] prod_o
);
  import wts_pkg::*;

  logic [ProdW-1:0] p_q;
  logic [MagW-1:0]  a_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [MagW:0]    upper;

  assign upper = {1'b0, p_q[ProdW-1:MagW]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(MagW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MagW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {upper, p_q[MagW-1:1]};
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign prod_o = p_q;
endmodule

### hw/rtl/wts_sqrt.sv
// Digit-serial floor square root, two radicand bits per cycle.
// Depends on wts_pkg.
`timescale 1ns / 1ps
module wts_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wts_pkg::ProdW-1:0] rad_i,
  output wts_pkg::unit_sts_t        sts_o,
  output logic [wts_pkg::RootW-1:0] root_o
);
  import wts_pkg::*;

  logic [ProdW-1:0] rad_q;
  logic [RootW+1:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [RootW+3:0] remx, trial;
  logic             ge;

  assign remx  = {rem_q, rad_q[ProdW-1:ProdW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = remx >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[ProdW-3:0], 2'b00};
      rem_q  <= ge ? (RootW+2)'(remx - trial) : remx[RootW+1:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign root_o = root_q;
endmodule

### hw/rtl/wts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wts_pkg.
`timescale 1ns / 1ps
module wts_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [wts_pkg::NumW-1:0] num_i,
  input  logic [wts_pkg::DenW-1:0] den_i,
  output wts_pkg::unit_sts_t       sts_o,
  output logic [wts_pkg::NumW-1:0] quot_o
);
  import wts_pkg::*;

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q, rem_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DenW:0]    remx;
  logic             ge;

  assign remx = {rem_q, num_q[NumW-1]};
  assign ge   = remx >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], ge};
      rem_q <= ge ? DenW'(remx - {1'b0, den_q}) : remx[DenW-1:0];
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign quot_o = num_q;
endmodule

### hw/rtl/waypoint_time_scheduler_top.sv
// Waypoint time scheduler top level: control sequencer, switch time table, I/O registers.
// Depends on wts_pkg, wts_mul, wts_sqrt and wts_div.
//
// Usage: one input beat on s_axis gives exactly one result beat on m_axis.
// tuser selects the beat kind: load a waypoint or report a time tick.
// A load runs three serial squares and one serial multiply for the effective speed,
// then a serial square root and a serial divide, one unit after the other.
// A tick walks the table one entry at a time through a read state and a compare
// state (one memory read port). A load into a full table and a tick on an empty
// table go straight to the result state.
// One item is in work at a time; s_axis_tready is high only while the sequencer
// is idle. The result register holds a beat until m_axis_tready takes it; a new
// item may be accepted meanwhile, and its result waits until the register frees.
// Reset clears count, index, running time, last position and the registers to their
// defaults; the table itself is not cleared. The user must write configuration through
// cfg_we_i/cfg_addr_i/cfg_wdata_i while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module waypoint_time_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_addr_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // waypoint_x, waypoint_y, waypoint_z, tick_time
  input  logic [wts_pkg::InDataW-1:0]   s_axis_tdata_i,
  // opcode, first_waypoint
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // index, changed flag, finished, switch time, status, zero fill
  output logic [wts_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import wts_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SSq    = 4'd1;
  localparam logic [3:0] SEff   = 4'd2;
  localparam logic [3:0] SSqrt  = 4'd3;
  localparam logic [3:0] SDiv   = 4'd4;
  localparam logic [3:0] STkRd  = 4'd5;
  localparam logic [3:0] STkCmp = 4'd6;
  localparam logic [3:0] SFin   = 4'd7;

  logic [3:0] state_q;
  logic [CoordW-1:0] start_q [3];
  logic [31:0] max_spd_q, settle_q;
  logic [SfW-1:0] spd_fac_q;

  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q, prev_q;
  logic [CoordW-1:0] last_q [3];
  logic [CoordW-1:0] wp_q [3];
  logic [TimeW-1:0] run_q, tick_q, rd_q;
  logic [TimeW-1:0] mem [MaxWp];
  logic [1:0] axis_q;
  logic [ProdW-1:0] sum_q;
  logic [DenW-1:0] eff_q;
  logic launch_q;

  logic [IdxW-1:0] r_idx_q;
  logic r_chg_q, r_fin_q;
  logic [TimeW-1:0] r_time_q;
  logic [1:0] r_st_q;
  logic m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  unit_sts_t mul_sts, sqrt_sts, div_sts;
  logic [ProdW-1:0] prod;
  logic [RootW-1:0] root;
  logic [NumW-1:0] quot;
  logic [MagW-1:0] mul_a, mul_b, mag;
  logic [MagW-1:0] diff;
  logic [SfW-1:0] sf_sat;
  logic [NumW+1:0] tsum;
  logic [TimeW-1:0] tsat;
  logic mem_we;
  logic s_fire, ld_first;
  logic [CntW-1:0] eff_cnt;

  assign s_axis_tready_o = (state_q == SIdle);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign ld_first = s_axis_tuser_i[1];
  assign eff_cnt = ld_first ? '0 : cnt_q;

  assign diff = {wp_q[axis_q][CoordW-1], wp_q[axis_q]}
              - {last_q[axis_q][CoordW-1], last_q[axis_q]};
  assign mag = diff[MagW-1] ? MagW'(-diff) : diff;
  assign sf_sat = (spd_fac_q > SfOne) ? SfOne : spd_fac_q;
  assign mul_a = (state_q == SEff) ? {1'b0, max_spd_q} : mag;
  assign mul_b = (state_q == SEff) ? MagW'(sf_sat) : mag;

  assign tsum = (NumW+2)'(quot) + (NumW+2)'(run_q) + (NumW+2)'(settle_q);
  assign tsat = (tsum[NumW+1:TimeW] != '0) ? {TimeW{1'b1}} : tsum[TimeW-1:0];
  assign mem_we = (state_q == SDiv) && div_sts.done;

  wts_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(launch_q && (state_q == SSq || state_q == SEff)),
    .a_i(mul_a), .b_i(mul_b), .sts_o(mul_sts), .prod_o(prod)
  );

  wts_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(launch_q && state_q == SSqrt),
    .rad_i(sum_q), .sts_o(sqrt_sts), .root_o(root)
  );

  wts_div u_div (
    .clk_i, .rst_ni,
    .start_i(launch_q && state_q == SDiv),
    .num_i({root, 16'h0000}), .den_i(eff_q), .sts_o(div_sts), .quot_o(quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[IdxW-1:0]] <= tsat;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q[0] <= '0;
      start_q[1] <= '0;
      start_q[2] <= '0;
      max_spd_q  <= 32'h0001_0000;
      spd_fac_q  <= SfOne;
      settle_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegStartX: start_q[0] <= cfg_wdata_i;
        RegStartY: start_q[1] <= cfg_wdata_i;
        RegStartZ: start_q[2] <= cfg_wdata_i;
        RegMaxSpd: max_spd_q  <= cfg_wdata_i;
        RegSpdFac: spd_fac_q  <= cfg_wdata_i[SfW-1:0];
        RegSettle: settle_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      idx_q     <= '0;
      run_q     <= '0;
      last_q[0] <= '0;
      last_q[1] <= '0;
      last_q[2] <= '0;
      launch_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      launch_q <= 1'b0;
      if (m_valid_q && m_axis_tready_i && (state_q != SFin)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (s_fire) begin
            r_chg_q  <= 1'b0;
            r_fin_q  <= 1'b0;
            r_time_q <= '0;
            r_st_q   <= StOk;
            tick_q   <= s_axis_tdata_i[135:96];
            if (s_axis_tuser_i[0] == OpLoad) begin
              if (ld_first) begin
                cnt_q  <= '0;
                idx_q  <= '0;
                run_q  <= '0;
                last_q <= start_q;
              end
              r_idx_q <= ld_first ? '0 : idx_q;
              wp_q[0] <= s_axis_tdata_i[31:0];
              wp_q[1] <= s_axis_tdata_i[63:32];
              wp_q[2] <= s_axis_tdata_i[95:64];
              sum_q   <= '0;
              axis_q  <= '0;
              if (eff_cnt >= CntW'(MaxWp)) begin
                r_st_q  <= StFull;
                state_q <= SFin;
              end else begin
                launch_q <= 1'b1;
                state_q  <= SSq;
              end
            end else begin
              prev_q <= idx_q;
              if (cnt_q == '0) begin
                r_idx_q <= idx_q;
                r_st_q  <= StEmpty;
                state_q <= SFin;
              end else begin
                if (CntW'(idx_q) >= cnt_q) begin
                  idx_q <= IdxW'(cnt_q - 1'b1);
                end
                state_q <= STkRd;
              end
            end
          end
        end
        SSq: begin
          if (mul_sts.done) begin
            sum_q    <= sum_q + prod;
            launch_q <= 1'b1;
            if (axis_q == 2'd2) begin
              state_q <= SEff;
            end else begin
              axis_q <= axis_q + 1'b1;
            end
          end
        end
        SEff: begin
          if (mul_sts.done) begin
            eff_q    <= (prod[47:16] == '0) ? 32'd1 : prod[47:16];
            launch_q <= 1'b1;
            state_q  <= SSqrt;
          end
        end
        SSqrt: begin
          if (sqrt_sts.done) begin
            launch_q <= 1'b1;
            state_q  <= SDiv;
          end
        end
        SDiv: begin
          if (div_sts.done) begin
            run_q    <= tsat;
            cnt_q    <= cnt_q + 1'b1;
            last_q   <= wp_q;
            r_time_q <= tsat;
            state_q  <= SFin;
          end
        end
        STkRd: state_q <= STkCmp;
        STkCmp: begin
          if ((CntW'(idx_q) + 1'b1 < cnt_q) && (tick_q >= rd_q)) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= STkRd;
          end else begin
            r_idx_q <= idx_q;
            r_chg_q <= (idx_q != prev_q);
            r_fin_q <= (CntW'(idx_q) + 1'b1 == cnt_q) && (tick_q >= rd_q);
            state_q <= SFin;
          end
        end
        SFin: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'b0, r_st_q, r_time_q, r_fin_q, r_chg_q,
                          OutIdxW'(r_idx_q)};
            state_q   <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
endmodule
